### hdl/xlb_pkg.sv
// shared types and constants for the xor linear basis engine
package xlb_pkg;

   localparam int Width = 62;
   localparam int CntW  = 63;
   localparam int IdxW  = 6;

   typedef logic [Width-1:0] vec_type;
   typedef logic [CntW-1:0]  cnt_type;
   typedef logic [IdxW-1:0]  idx_type;

   typedef enum logic [2:0] {
      CMD_INSERT   = 3'd0,
      CMD_CONTAINS = 3'd1,
      CMD_MAX      = 3'd2,
      CMD_MIN      = 3'd3,
      CMD_KSMALL   = 3'd4,
      CMD_KLARGE   = 3'd5,
      CMD_COUNT    = 3'd6,
      CMD_CLEAR    = 3'd7
   } cmd_type;

   // per-cell control for the row of cells that holds the rotating data
   typedef struct packed {
      logic    write;
      logic    clear;
      vec_type wdata;
   } cell_ctl_type;

endpackage

### hdl/xlb_cell.sv
// one basis row cell: holds a vector and passes it to its neighbour each cycle that shift is high
module xlb_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             shift,
   input  xlb_pkg::cell_ctl_type ctl,
   input  xlb_pkg::vec_type row_prev,
   output xlb_pkg::vec_type row_out
);
   import xlb_pkg::*;

   vec_type row_ff, row_in;

   always_comb begin
      row_in = row_ff;
      if (ctl.clear) begin
         row_in = '0;
      end else if (ctl.write) begin
         row_in = ctl.wdata;
      end else if (shift) begin
         row_in = row_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else begin
         row_ff <= row_in;
      end
   end

   assign row_out = row_ff;
endmodule

### hdl/xor_linear_basis_engine_unit.sv
// top level of the xor linear basis engine: control, datapath and the row of cells
//
// Each request passes from acceptance through one scan state per basis bit, a finish
// state and a state presenting the response, which waits there until it is taken; the
// next request is accepted at the earliest in the cycle after the response is taken.
// The 62 basis rows sit in a circular chain of cells that rotates by one place a cycle
// during a scan, so the row for bit 61 down to bit 0 is presented to the single scan
// datapath in turn; after the scan the chain is back in place. A clear request takes
// the same time. One request is worked on at a time. Requests and responses use
// valid/ready streams.
module xor_linear_basis_engine_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // cmd[2:0], operand_value[64:3], rank[127:65]
   input  logic [127:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // answer[61:0], subset_count[124:62], is_member[125], was_added[126],
   // rank_invalid[127], basis_size[133:128]
   output logic [135:0] rsp_tdata
);
   import xlb_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE, S_OUT} state_type;

   state_type state_ff, state_in;
   cmd_type   cmd_ff;
   vec_type   x_ff, x_in, res_ff, res_in, path_ff, path_in;
   cnt_type   k_ff, k_in, cnt_ff, cnt_in, acc_ff, acc_in;
   idx_type   bit_ff, bit_in, size_ff, size_in;
   logic      stop_ff, stop_in, flag_ff, flag_in, bad_ff, bad_in;
   logic [135:0] rsp_ff, rsp_in;

   vec_type      rows [Width];
   cell_ctl_type ctl  [Width];
   logic         shift;
   vec_type      head;

   assign shift = (state_ff == S_SCAN);
   assign head  = rows[Width-1];

   for (genvar g = 0; g < Width; g++) begin : g_cell
      xlb_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift    (shift),
         .ctl      (ctl[g]),
         .row_prev (g == 0 ? rows[Width-1] : rows[(g == 0) ? 0 : g-1]),
         .row_out  (rows[g])
      );
   end

   // scan datapath, head row is the row for bit bit_ff
   logic    bx, bp, hz, wr_head, want;
   vec_type y;
   cnt_type half, total, kk;

   always_comb begin
      state_in = state_ff;
      x_in = x_ff; res_in = res_ff; path_in = path_ff;
      k_in = k_ff; cnt_in = cnt_ff; acc_in = acc_ff;
      bit_in = bit_ff; size_in = size_ff; stop_in = stop_ff;
      flag_in = flag_ff; bad_in = bad_ff; rsp_in = rsp_ff;
      wr_head = 1'b0;
      bx = x_ff[bit_ff]; bp = path_ff[bit_ff]; hz = (head == '0);
      y = x_ff ^ head; half = cnt_ff >> 1; want = 1'b0;
      total = cnt_type'(1) << size_ff;
      kk = '0;
      for (int i = 0; i < Width; i++) ctl[i] = '{write: 1'b0, clear: 1'b0, wdata: '0};
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               x_in = req_tdata[64:3]; res_in = '0; path_in = '0; acc_in = '0;
               cnt_in = total; bit_in = idx_type'(Width-1); stop_in = 1'b0;
               flag_in = 1'b0; bad_in = 1'b0;
               kk = req_tdata[127:65];
               if (cmd_type'(req_tdata[2:0]) == CMD_KSMALL ||
                   cmd_type'(req_tdata[2:0]) == CMD_KLARGE) begin
                  if (kk == '0 || kk > total) bad_in = 1'b1;
               end
               k_in = (cmd_type'(req_tdata[2:0]) == CMD_KLARGE) ? total - kk + 1'b1 : kk;
               if (cmd_type'(req_tdata[2:0]) == CMD_CLEAR) begin
                  for (int i = 0; i < Width; i++) ctl[i].clear = 1'b1;
                  size_in = '0;
               end
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (!stop_ff) begin
               case (cmd_ff) inside
                  CMD_INSERT, CMD_CONTAINS: begin
                     if (bx) begin
                        if (hz) begin
                           stop_in = 1'b1;
                           if (cmd_ff == CMD_INSERT) begin
                              wr_head = 1'b1; flag_in = 1'b1; size_in = size_ff + 1'b1;
                           end
                        end else begin
                           x_in = y;
                        end
                     end
                  end
                  CMD_MAX: if (y > x_ff) x_in = y;
                  CMD_MIN: if (y < x_ff) x_in = y;
                  CMD_KSMALL, CMD_KLARGE: begin
                     if (!hz) begin
                        cnt_in = half;
                        if (k_ff > half) begin
                           want = 1'b1; k_in = k_ff - half;
                        end
                        if (res_ff[bit_ff] != want) res_in = res_ff ^ head;
                     end
                  end
                  CMD_COUNT: begin
                     if (!hz) begin
                        cnt_in = half;
                        if (bx) acc_in = acc_ff + half;
                        if (bp != bx) path_in = path_ff ^ head;
                     end else if (bp != bx) begin
                        if (bx) acc_in = acc_ff + cnt_ff;
                        stop_in = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
            // the row written lands in cell 0 since the chain shifts this edge
            if (wr_head) ctl[0] = '{write: 1'b1, clear: 1'b0, wdata: x_ff};
            bit_in = bit_ff - 1'b1;
            if (bit_ff == '0) state_in = S_DONE;
         end
         S_DONE: begin
            rsp_in = '0;
            rsp_in[133:128] = size_ff;
            case (cmd_ff) inside
               CMD_INSERT:           rsp_in[126] = flag_ff;
               CMD_CONTAINS:         rsp_in[125] = !stop_ff && (x_ff == '0);
               CMD_MAX, CMD_MIN:     rsp_in[61:0] = x_ff;
               CMD_KSMALL, CMD_KLARGE: begin
                  rsp_in[127] = bad_ff;
                  if (!bad_ff) rsp_in[61:0] = res_ff;
               end
               CMD_COUNT:            rsp_in[124:62] = acc_ff;
               default: ;
            endcase
            state_in = S_OUT;
         end
         S_OUT: if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         size_ff  <= '0;
      end else begin
         state_ff <= state_in;
         size_ff  <= size_in;
      end
      if (state_ff == S_IDLE && req_tvalid) cmd_ff <= cmd_type'(req_tdata[2:0]);
      x_ff <= x_in; res_ff <= res_in; path_ff <= path_in;
      k_ff <= k_in; cnt_ff <= cnt_in; acc_ff <= acc_in;
      bit_ff <= bit_in; stop_ff <= stop_in; flag_ff <= flag_in; bad_ff <= bad_in;
      rsp_ff <= rsp_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = rsp_ff;

   a_size: assert property (@(posedge clock) disable iff (reset)
      size_ff <= idx_type'(Width)) else $error("basis size overflow");
   a_grow: assert property (@(posedge clock) disable iff (reset)
      size_ff != $past(size_ff) |-> $past(state_ff) == S_SCAN || $past(state_ff) == S_IDLE)
      else $error("size changed outside scan");
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $countones(rsp_tdata[127:125]) <= 1) else $error("several flags");
endmodule
